/* sv/pwbt_pkg.sv */
package pwbt_pkg;

  localparam int DATA_W    = 8;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_QUEUE_DEPTH = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_PULSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PULSE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP    = 3'd4;

  localparam logic [TICK_W-1:0] RST_START_PULSE = 16'd3000;
  localparam logic [TICK_W-1:0] RST_ONE_PULSE   = 16'd2000;
  localparam logic [TICK_W-1:0] RST_ZERO_PULSE  = 16'd1000;
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD  = 16'd5000;
  localparam logic [TICK_W-1:0] RST_BYTE_GAP    = 16'd11000;

  // symbols per byte: start plus eight data bits, index of the last one
  localparam logic [3:0] SYM_LAST = 4'd8;

  typedef enum logic {
    ITEM_PUSH = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [DATA_W-1:0] data;
    logic              mend;
  } item_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] wdata;
  } bq_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic              last_free;
    logic [DATA_W-1:0] head;
  } bq_stat_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_pulse;
    logic [TICK_W-1:0] one_pulse;
    logic [TICK_W-1:0] zero_pulse;
    logic [TICK_W-1:0] bit_period;
    logic [TICK_W-1:0] byte_gap;
  } cfg_t;

endpackage

/* sv/pwbt_front.sv */
module pwbt_front import pwbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              message_end,
  output logic              item_valid,
  output item_t             item,
  input  logic              item_take
);

  item_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       put;
  item_t      beat;

  assign in_ready   = (cnt != 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = ent[rp];
  assign put        = in_valid && in_ready;

  always_comb begin
    beat.kind = func ? ITEM_TICK : ITEM_PUSH;
    beat.data = data_byte;
    beat.mend = message_end;
  end

  always_ff @(posedge clk) begin
    if (put) begin
      ent[wp] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (put) begin
        wp <= ~wp;
      end
      if (item_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, put} - {1'b0, item_take};
    end
  end

endmodule

/* sv/pwbt_byteq.sv */
module pwbt_byteq import pwbt_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  bq_cmd_t  cmd,
  output bq_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  rp_next;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] head;

  always_comb begin
    rp_next = rp;
    if (cmd.pop) begin
      rp_next = (rp == PTR_LAST) ? '0 : rp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wp] <= cmd.wdata;
    end
    // registered head read, with the beat being written passed through
    if (cmd.push && (wp == rp_next)) begin
      head <= cmd.wdata;
    end else begin
      head <= mem[rp_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      rp <= rp_next;
      if (cmd.push) begin
        wp    <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_FULL);
  assign stat.last_free = (count == CNT_LAST);
  assign stat.head      = head;

endmodule

/* sv/pwbt_back.sv */
module pwbt_back import pwbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_take,
  output bq_cmd_t              bq_cmd,
  input  bq_stat_t             bq_stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 line_level,
  output logic                 busy_res,
  output logic                 push_accepted,
  output logic                 message_done
);

  typedef enum logic [1:0] {
    M_TAKE,
    M_PRE,
    M_RUN,
    M_POST
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] shift;
    logic [3:0]        sym;
    logic              high;
    logic [TICK_W-1:0] cnt;
    logic              sending;
  } enc_t;

  typedef struct packed {
    enc_t s;
    logic ended;
    logic pop;
  } step_t;

  function automatic logic [TICK_W-1:0] high_time(enc_t s, cfg_t c);
    logic [2:0] sel;
    sel = 3'(s.sym - 4'd1);
    if (s.sym == 4'd0) begin
      return c.start_pulse;
    end
    return s.shift[sel] ? c.one_pulse : c.zero_pulse;
  endfunction

  function automatic step_t next_phase(enc_t s, cfg_t c, logic qempty,
                                       logic [DATA_W-1:0] head);
    step_t             r;
    logic [TICK_W-1:0] ht;
    r.s     = s;
    r.ended = 1'b0;
    r.pop   = 1'b0;
    ht      = high_time(s, c);
    if (s.high) begin
      r.s.high = 1'b0;
      if (s.sym >= SYM_LAST) begin
        r.s.cnt = c.byte_gap;
      end else begin
        r.s.cnt = (c.bit_period > ht) ? c.bit_period - ht : '0;
      end
    end else if (s.sym >= SYM_LAST) begin
      r.s.sym = 4'd0;
      if (qempty) begin
        r.s.sending = 1'b0;
        r.s.cnt     = '0;
        r.ended     = 1'b1;
      end else begin
        r.s.shift = head;
        r.pop     = 1'b1;
        r.s.high  = 1'b1;
        r.s.cnt   = c.start_pulse;
      end
    end else begin
      r.s.sym  = s.sym + 4'd1;
      r.s.high = 1'b1;
      r.s.cnt  = high_time(r.s, c);
    end
    return r;
  endfunction

  // one tick of the running phase
  function automatic step_t run_step(enc_t s, cfg_t c, logic qempty,
                                     logic [DATA_W-1:0] head);
    step_t r;
    r.s     = s;
    r.ended = 1'b0;
    r.pop   = 1'b0;
    if (s.cnt == 16'd1) begin
      r = next_phase(s, c, qempty, head);
    end else begin
      r.s.cnt = s.cnt - 16'd1;
    end
    return r;
  endfunction

  cfg_t  cfg;
  mode_t mode;
  mode_t mode_next;
  enc_t  st;
  enc_t  st_next;
  enc_t  s0;
  step_t r;
  logic  msg_ready;
  logic  msg_ready_next;
  logic  res_line;
  logic  res_line_next;
  logic  slot_free;
  logic  go_run;
  logic  emit;
  logic  e_line;
  logic  e_acc;
  logic  e_done;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pulse <= RST_START_PULSE;
      cfg.one_pulse   <= RST_ONE_PULSE;
      cfg.zero_pulse  <= RST_ZERO_PULSE;
      cfg.bit_period  <= RST_BIT_PERIOD;
      cfg.byte_gap    <= RST_BYTE_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_PULSE: cfg.start_pulse <= cfg_data;
        REG_ONE_PULSE:   cfg.one_pulse   <= cfg_data;
        REG_ZERO_PULSE:  cfg.zero_pulse  <= cfg_data;
        REG_BIT_PERIOD:  cfg.bit_period  <= cfg_data;
        REG_BYTE_GAP:    cfg.byte_gap    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next      = mode;
    st_next        = st;
    msg_ready_next = msg_ready;
    res_line_next  = res_line;
    item_take      = 1'b0;
    bq_cmd.push    = 1'b0;
    bq_cmd.pop     = 1'b0;
    bq_cmd.wdata   = item.data;
    emit           = 1'b0;
    e_line         = 1'b0;
    e_acc          = 1'b0;
    e_done         = 1'b0;
    s0             = st;
    go_run         = 1'b0;
    r.s            = st;
    r.ended        = 1'b0;
    r.pop          = 1'b0;
    if (slot_free) begin
      case (mode)
        M_TAKE: begin
          if (item_valid) begin
            item_take = 1'b1;
            if (item.kind == ITEM_PUSH) begin
              emit   = 1'b1;
              e_line = st.sending && st.high;
              if (!msg_ready && !st.sending && !bq_stat.full) begin
                e_acc       = 1'b1;
                bq_cmd.push = 1'b1;
                if (item.mend || bq_stat.last_free) begin
                  msg_ready_next = 1'b1;
                end
              end
            end else begin
              go_run = st.sending;
              if (!st.sending && msg_ready) begin
                msg_ready_next = 1'b0;
                if (!bq_stat.empty) begin
                  s0.shift   = bq_stat.head;
                  s0.sym     = 4'd0;
                  s0.high    = 1'b1;
                  s0.cnt     = cfg.start_pulse;
                  s0.sending = 1'b1;
                  bq_cmd.pop = 1'b1;
                  if (cfg.start_pulse == '0) begin
                    mode_next = M_PRE;
                  end else begin
                    go_run = 1'b1;
                  end
                end
              end
              st_next = s0;
              if (go_run) begin
                r       = run_step(s0, cfg, bq_stat.empty, bq_stat.head);
                st_next = r.s;
                if (r.pop) begin
                  bq_cmd.pop = 1'b1;
                end
                if (!r.ended && r.s.sending && (r.s.cnt == '0)) begin
                  mode_next     = M_POST;
                  res_line_next = s0.high;
                end else begin
                  emit   = 1'b1;
                  e_line = s0.high;
                  e_done = r.ended;
                end
              end else if (mode_next == M_TAKE) begin
                emit = 1'b1;
              end
            end
          end
        end
        M_PRE: begin
          r          = next_phase(st, cfg, bq_stat.empty, bq_stat.head);
          st_next    = r.s;
          bq_cmd.pop = r.pop;
          if (r.ended) begin
            emit      = 1'b1;
            e_done    = 1'b1;
            mode_next = M_TAKE;
          end else if (r.s.cnt != '0) begin
            mode_next = M_RUN;
          end
        end
        M_RUN: begin
          r          = run_step(st, cfg, bq_stat.empty, bq_stat.head);
          st_next    = r.s;
          bq_cmd.pop = r.pop;
          if (!r.ended && r.s.sending && (r.s.cnt == '0)) begin
            mode_next     = M_POST;
            res_line_next = st.high;
          end else begin
            emit      = 1'b1;
            e_line    = st.high;
            e_done    = r.ended;
            mode_next = M_TAKE;
          end
        end
        M_POST: begin
          r          = next_phase(st, cfg, bq_stat.empty, bq_stat.head);
          st_next    = r.s;
          bq_cmd.pop = r.pop;
          if (r.ended || (r.s.cnt != '0)) begin
            emit      = 1'b1;
            e_line    = res_line;
            e_done    = r.ended;
            mode_next = M_TAKE;
          end
        end
        default: mode_next = M_TAKE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_TAKE;
      st        <= '0;
      msg_ready <= 1'b0;
      res_line  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      st        <= st_next;
      msg_ready <= msg_ready_next;
      res_line  <= res_line_next;
      if (emit) begin
        out_valid     <= 1'b1;
        line_level    <= e_line;
        busy_res      <= st_next.sending;
        push_accepted <= e_acc;
        message_done  <= e_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    bq_cmd.pop |-> !bq_stat.empty)
    else $error("byte popped from an empty queue");

  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    bq_cmd.push |-> (!msg_ready && !st.sending))
    else $error("byte stored while a message is pending");

  a_settled: assert property (@(posedge clk) disable iff (rst)
    (mode == M_TAKE && st.sending) |-> (st.cnt != '0))
    else $error("running phase with no ticks left");

  a_mode_sending: assert property (@(posedge clk) disable iff (rst)
    (mode != M_TAKE) |-> st.sending)
    else $error("phase stepping while not sending");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_done) |-> !busy_res)
    else $error("done reported while still busy");

endmodule

/* sv/pulse_width_byte_transmitter.sv */
// pulse width byte transmitter
// input channel (in_valid/in_ready): one beat is either a byte push
// (func = 0, data_byte, message_end) or one timer tick (func = 1).
// output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: line_level, busy_res, push_accepted, message_done.
// configuration: cfg_write with cfg_index 0..4 sets start_pulse, one_pulse,
// zero_pulse, bit_period, byte_gap; other indexes are ignored. write only
// while no beat is in flight.
// throughput: one beat per cycle while out_ready is high and no zero-length
// phase is being skipped. a beat's result is registered first in the input
// queue and then in the output register. a tick that ends a phase whose
// successor has zero length delays later beats while the sequencer steps one
// phase per cycle past them; a zero start pulse at message start does too.
// a two-entry input queue decouples the ports from the sequencer, so input
// is taken while a result waits; when out_ready is low the sequencer holds
// and input stops once that queue is full.
// reset (rst, synchronous): queues empty, line idle, registers at defaults.
module pulse_width_byte_transmitter import pwbt_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [DATA_W-1:0]    data_byte,
  input  logic                 message_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 line_level,
  output logic                 busy_res,
  output logic                 push_accepted,
  output logic                 message_done
);

  logic     item_valid;
  item_t    item;
  logic     item_take;
  bq_cmd_t  bq_cmd;
  bq_stat_t bq_stat;

  pwbt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .data_byte   (data_byte),
    .message_end (message_end),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  pwbt_byteq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_byteq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (bq_cmd),
    .stat (bq_stat)
  );

  pwbt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .bq_cmd        (bq_cmd),
    .bq_stat       (bq_stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_level    (line_level),
    .busy_res      (busy_res),
    .push_accepted (push_accepted),
    .message_done  (message_done)
  );

endmodule
